[design/cms_pkg.sv]
// Shared types and constants for the count-min sketch unit.
package cms_pkg;

   localparam int NUM_SEEDS   = 4;
   localparam int SEED_SEL_W  = 2;
   localparam int SEED_W      = 64;
   localparam int KEY_W       = 64;
   localparam int DELTA_W     = 32;
   localparam int CNT_W       = 32;
   localparam int HALF_W      = 32;
   localparam int CSR_INDEX_W = 8;

   // Seed register values after reset
   localparam logic [SEED_W-1:0] SEED_RESET [NUM_SEEDS] = '{
      64'd1, 64'd3, 64'd5, 64'd7
   };

   // Item action codes
   localparam logic ACTION_UPDATE   = 1'b0;
   localparam logic ACTION_ESTIMATE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_LL,
      ST_MUL_LH,
      ST_MUL_HL,
      ST_ADDR,
      ST_READ,
      ST_APPLY,
      ST_RESULT
   } state_type;

   // Partial product selection for the shared multiplier
   typedef enum logic [1:0] {
      MUL_LL,
      MUL_LH,
      MUL_HL
   } mul_sel_type;

   typedef struct packed {
      logic        clr_wr;
      logic        item_load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        addr_load;
      logic        mem_rd;
      logic        mem_wr;
      logic        min_upd;
      logic        row_inc;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic last_row;
      logic is_estimate;
   } status_type;

endpackage

[design/cms_ctrl.sv]
// Controller state machine for the count-min sketch unit.
module cms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  cms_pkg::status_type  status,
   output cms_pkg::cmd_type     cmd
);
   import cms_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Result register can take a new value when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_MUL_LL;
         ST_MUL_LL: state_in = ST_MUL_LH;
         ST_MUL_LH: state_in = ST_MUL_HL;
         ST_MUL_HL: state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_READ;
         ST_READ:   state_in = ST_APPLY;
         ST_APPLY: begin
            if (!status.last_row) begin
               state_in = ST_MUL_LL;
            end else if (status.is_estimate) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESULT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_LL;
      unique case (state_ff)
         ST_CLEAR:  cmd.clr_wr = 1'b1;
         ST_IDLE:   cmd.item_load = req_valid;
         ST_MUL_LL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LL;
         end
         ST_MUL_LH: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_LH;
            cmd.acc_load = 1'b1;
         end
         ST_MUL_HL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HL;
            cmd.acc_add = 1'b1;
         end
         ST_ADDR:   cmd.addr_load = 1'b1;
         ST_READ:   cmd.mem_rd = 1'b1;
         ST_APPLY: begin
            cmd.mem_wr  = !status.is_estimate;
            cmd.min_upd = status.is_estimate;
            cmd.row_inc = !status.last_row;
         end
         ST_RESULT: cmd.out_load = out_free;
         default:   cmd = '0;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/cms_dpath.sv]
// Datapath for the count-min sketch unit: seeds, hash multiplier, counter memory, minimum.
module cms_dpath #(
   parameter int ROWS       = 4,
   parameter int INDEX_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cms_pkg::cmd_type                      cmd,
   output cms_pkg::status_type                   status,
   input  logic                                  req_action,
   input  logic [cms_pkg::KEY_W-1:0]             req_key,
   input  logic signed [cms_pkg::DELTA_W-1:0]    req_delta,
   input  logic                                  csr_wr,
   input  logic [cms_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cms_pkg::SEED_W-1:0]            csr_data,
   output logic signed [cms_pkg::CNT_W-1:0]      rsp_estimate_value
);
   import cms_pkg::*;

   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int DEPTH  = ROWS * (2 ** INDEX_BITS);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [SEED_W-1:0]         seed_ff [NUM_SEEDS];
   logic                      action_ff;
   logic [KEY_W-1:0]          key_ff;
   logic signed [DELTA_W-1:0] delta_ff;
   logic [2*HALF_W-1:0]       mul_ff;
   logic [HALF_W-1:0]         acc_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic [CNT_W-1:0]          rd_ff;
   logic [CNT_W-1:0]          min_ff;
   logic [CNT_W-1:0]          est_ff;
   logic [ROW_W-1:0]          row_ff;
   logic [ADDR_W-1:0]         clr_ff;
   logic [CNT_W-1:0]          mem [DEPTH];

   logic [3:0]                row_ext;
   logic [SEED_W-1:0]         seed_cur;
   logic [HALF_W-1:0]         mul_a, mul_b;
   logic [2*HALF_W-1:0]       mul_in;
   logic [HALF_W-1:0]         hash_sum;
   logic [INDEX_BITS-1:0]     slot_index;
   logic [ADDR_W-1:0]         addr_in;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [CNT_W-1:0]          wr_data;
   logic                      take_min;

   // Seed registers, bit 0 always set
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_wr && (csr_index < CSR_INDEX_W'(NUM_SEEDS))) begin
         seed_ff[csr_index[SEED_SEL_W-1:0]] <= csr_data | SEED_W'(1);
      end
   end

   // Accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         action_ff <= req_action;
         key_ff    <= req_key;
         delta_ff  <= req_delta;
      end
   end

   // Row counter; rows past the fourth reuse seeds modulo four
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else if (cmd.item_load) begin
         row_ff <= '0;
      end else if (cmd.row_inc) begin
         row_ff <= row_ff + ROW_W'(1);
      end
   end

   assign row_ext  = 4'(row_ff);
   assign seed_cur = seed_ff[row_ext[SEED_SEL_W-1:0]];

   // Shared 32x32 multiplier over the three partial products of the low 64 bits
   always_comb begin
      case (cmd.mul_sel)
         MUL_LL: begin
            mul_a = seed_cur[HALF_W-1:0];
            mul_b = key_ff[HALF_W-1:0];
         end
         MUL_LH: begin
            mul_a = seed_cur[HALF_W-1:0];
            mul_b = key_ff[2*HALF_W-1:HALF_W];
         end
         MUL_HL: begin
            mul_a = seed_cur[2*HALF_W-1:HALF_W];
            mul_b = key_ff[HALF_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) mul_ff <= mul_in;
      if (cmd.acc_load) begin
         acc_ff <= mul_ff[2*HALF_W-1:HALF_W];
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + mul_ff[HALF_W-1:0];
      end
   end

   // Upper half of the product gives the slot; top bits form the index
   assign hash_sum   = acc_ff + mul_ff[HALF_W-1:0];
   assign slot_index = hash_sum[HALF_W-1 -: INDEX_BITS];
   assign addr_in    = ADDR_W'({row_ff, slot_index});

   always_ff @(posedge clock) begin
      if (cmd.addr_load) addr_ff <= addr_in;
   end

   // Clearing pass pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + ADDR_W'(1);
      end
   end

   // Counter memory: one write port, one registered read port
   assign wr_en   = cmd.clr_wr || cmd.mem_wr;
   assign wr_addr = cmd.clr_wr ? clr_ff : addr_ff;
   assign wr_data = cmd.clr_wr ? '0 : rd_ff + delta_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.mem_rd) rd_ff <= mem[addr_ff];
   end

   // Running signed minimum across rows
   assign take_min = (row_ff == '0) || ($signed(rd_ff) < $signed(min_ff));

   always_ff @(posedge clock) begin
      if (cmd.min_upd && take_min) min_ff <= rd_ff;
      if (cmd.out_load) est_ff <= min_ff;
   end

   assign rsp_estimate_value = $signed(est_ff);

   assign status.clear_done  = (clr_ff == ADDR_W'(DEPTH - 1));
   assign status.last_row    = (row_ff == ROW_W'(ROWS - 1));
   assign status.is_estimate = (action_ff == ACTION_ESTIMATE);

endmodule

[design/count_min_sketch_unit.sv]
// Count-min sketch unit: ROWS rows of 2^INDEX_BITS signed 32-bit counters, multiply-shift
// hashing with one odd 64-bit seed per row (row r uses seed register r mod 4). One transaction
// is processed at a time. After acceptance each row goes through three partial products
// on a single shared 32x32 multiplier, address formation, counter read, then write-back or
// minimum update, all through one counter memory with one write and one read port. An
// estimate then loads the result register once it is free. After reset, a clearing pass
// zeroes all ROWS * 2^INDEX_BITS entries (4096 by default), one entry per cycle, with
// req_stall held high; seed writes are taken throughout. A finished estimate waits in the
// result register while the next transaction is accepted.
module count_min_sketch_unit #(
   parameter int ROWS       = 4,
   parameter int INDEX_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [cms_pkg::KEY_W-1:0]             req_key,
   input  logic signed [cms_pkg::DELTA_W-1:0]    req_delta,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cms_pkg::CNT_W-1:0]      rsp_estimate_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cms_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cms_pkg::SEED_W-1:0]            csr_data
);
   import cms_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cms_dpath #(
      .ROWS       (ROWS),
      .INDEX_BITS (INDEX_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_key            (req_key),
      .req_delta          (req_delta),
      .csr_wr             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_estimate_value (rsp_estimate_value)
   );

   // No transaction is taken right after reset, when the clearing pass begins
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> req_stall)
      else $error("transaction accepted straight after reset");

   // The result register is only loaded when it is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("pending result overwritten");

   // Counter read and write never share a cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |-> !(cmd.mem_wr || cmd.clr_wr))
      else $error("counter read and write in the same cycle");

   // An accepted transaction cannot raise a result in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result raised directly after acceptance");

endmodule

[bench/count_min_sketch_checker.sv]
`timescale 1ns / 100ps
// Checker for the count-min sketch unit: mirrors the sketch and compares every estimate.
module count_min_sketch_checker #(
   parameter int ROWS       = 4,
   parameter int INDEX_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_action,
   input  logic [cms_pkg::KEY_W-1:0]          req_key,
   input  logic signed [cms_pkg::DELTA_W-1:0] req_delta,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [cms_pkg::CNT_W-1:0]   rsp_estimate_value,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [cms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cms_pkg::SEED_W-1:0]         csr_data,
   output int                                 mismatches,
   output int                                 estimates_pending
);
   import cms_pkg::*;

   localparam int BUCKETS = 2 ** INDEX_BITS;

   // Mirror of the seed registers and the counter rows
   logic [SEED_W-1:0]       row_seeds [NUM_SEEDS];
   logic signed [CNT_W-1:0] sketch [ROWS][BUCKETS];
   logic signed [CNT_W-1:0] expected_estimates [$];
   logic signed [CNT_W-1:0] expected_value;

   initial begin
      mismatches        = 0;
      estimates_pending = 0;
   end

   // Multiply-shift hash: top INDEX_BITS of the low 64 bits of seed * key
   function automatic int bucket_index(input int row, input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] product;
      product = row_seeds[row % NUM_SEEDS] * key;
      return int'(product >> (KEY_W - INDEX_BITS));
   endfunction

   // Smallest addressed counter across the rows, signed order
   function automatic logic signed [CNT_W-1:0] row_min_count(input logic [KEY_W-1:0] key);
      logic signed [CNT_W-1:0] lowest;
      logic signed [CNT_W-1:0] value;
      lowest = sketch[0][bucket_index(0, key)];
      for (int r = 1; r < ROWS; r++) begin
         value = sketch[r][bucket_index(r, key)];
         if (value < lowest) lowest = value;
      end
      return lowest;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SEEDS; s++) row_seeds[s] = SEED_RESET[s];
         for (int r = 0; r < ROWS; r++)
            for (int b = 0; b < BUCKETS; b++) sketch[r][b] = '0;
         expected_estimates.delete();
         mismatches <= 0;
      end else begin
         // results first: a transaction accepted at this edge cannot be answered yet
         if (rsp_valid && !rsp_stall) begin
            if (expected_estimates.size() == 0) begin
               $display("%0t: unexpected estimate, expected none, actual %0d",
                        $time, rsp_estimate_value);
               mismatches <= mismatches + 1;
            end else begin
               expected_value = expected_estimates.pop_front();
               if (rsp_estimate_value !== expected_value) begin
                  $display("%0t: estimate_value mismatch, expected %0d, actual %0d",
                           $time, expected_value, rsp_estimate_value);
                  mismatches <= mismatches + 1;
               end
            end
         end

         // seed write; indexes past the last seed are dropped
         if (csr_valid && csr_ready && csr_index < NUM_SEEDS)
            row_seeds[csr_index[SEED_SEL_W-1:0]] = csr_data | SEED_W'(1);

         // request: update every row, or queue the estimate
         if (req_valid && !req_stall) begin
            if (req_action == ACTION_ESTIMATE) begin
               expected_estimates.push_back(row_min_count(req_key));
            end else begin
               for (int r = 0; r < ROWS; r++)
                  sketch[r][bucket_index(r, req_key)] += req_delta;
            end
         end
      end
      estimates_pending <= expected_estimates.size();
   end

endmodule

[bench/count_min_sketch_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the count-min sketch unit: stimulus, seed programming and verdict.
module count_min_sketch_unit_tb;
   import cms_pkg::*;

   localparam int ROWS              = 4;
   localparam int INDEX_BITS        = 10;
   localparam int CLEAR_CYCLES      = ROWS << INDEX_BITS;
   localparam int BUSY_CYCLES       = 2 + 6 * ROWS;
   localparam int SETTLE_CYCLES     = 2 * BUSY_CYCLES + 8;
   localparam int WATCHDOG_LIMIT    = 4 * CLEAR_CYCLES + 1000;
   localparam int PHASES            = 6;
   localparam int ITEMS_PER_PHASE   = 200;
   localparam int POOL_KEYS         = 24;

   // Seed register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_ROW0 = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_ROW1 = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_ROW2 = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_ROW3 = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PAST_LAST = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_INDEX_TOP = 8'hFF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_action = ACTION_UPDATE;
   logic [KEY_W-1:0]          req_key = '0;
   logic signed [DELTA_W-1:0] req_delta = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [CNT_W-1:0]   rsp_estimate_value;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [SEED_W-1:0]         csr_data = '0;

   int mismatches;
   int estimates_pending;
   int idle_cycles = 0;
   int stall_left = 0;
   int burst_left = 0;
   int gap_max = 8;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   count_min_sketch_unit #(
      .ROWS       (ROWS),
      .INDEX_BITS (INDEX_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_key            (req_key),
      .req_delta          (req_delta),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_estimate_value (rsp_estimate_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   count_min_sketch_checker #(
      .ROWS       (ROWS),
      .INDEX_BITS (INDEX_BITS)
   ) checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_key            (req_key),
      .req_delta          (req_delta),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_estimate_value (rsp_estimate_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatches         (mismatches),
      .estimates_pending  (estimates_pending)
   );

   // Receiver back-pressure: free and stalled runs of random length; every stalled run is followed by a free run
   always @(posedge clock) begin
      if (stall_left == 0) begin
         if (!rsp_stall && $urandom_range(0, 2) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 30);
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                    : $urandom_range(1, 20);
         end
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // Watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [63:0] rand_word64();
      return {$urandom, $urandom};
   endfunction

   // One request transaction; bursts end in a random gap when gaps are enabled
   task automatic send_item(input logic action, input logic [KEY_W-1:0] key,
                            input logic signed [DELTA_W-1:0] delta);
      req_valid  <= 1'b1;
      req_action <= action;
      req_key    <= key;
      req_delta  <= delta;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   // Seed write; valid stays up so back-to-back writes need no lowering
   task automatic write_seed(input logic [CSR_INDEX_W-1:0] index,
                             input logic [SEED_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Wait for every estimate, then let a last update finish in the unit
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (estimates_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Hand-picked keys under the reset seeds 1, 3, 5, 7:
   // key 0 hits bucket 0 in every row, all ones bucket 1023, bit 63 bucket 512,
   // 2^54 buckets 1/3/5/7, and 0x0060... shares only row 0 with 2^54.
   task automatic run_directed();
      logic [KEY_W-1:0] key_base;
      logic [KEY_W-1:0] key_shared;
      key_base   = 64'h0040_0000_0000_0000;
      key_shared = 64'h0060_0000_0000_0000;
      send_item(ACTION_ESTIMATE, '0, '0);
      send_item(ACTION_UPDATE, '0, 32'sh7FFF_FFFF);
      send_item(ACTION_UPDATE, '0, 32'sd1);
      send_item(ACTION_ESTIMATE, '0, '0);
      send_item(ACTION_UPDATE, '1, 32'sh8000_0000);
      send_item(ACTION_UPDATE, '1, -32'sd1);
      send_item(ACTION_ESTIMATE, '1, '0);
      send_item(ACTION_UPDATE, 64'h8000_0000_0000_0000, -32'sd1);
      send_item(ACTION_ESTIMATE, 64'h8000_0000_0000_0000, '1);
      send_item(ACTION_UPDATE, key_base, 32'sd100);
      send_item(ACTION_UPDATE, key_shared, 32'sd5);
      send_item(ACTION_ESTIMATE, key_shared, '0);
      send_item(ACTION_ESTIMATE, key_base, '0);
      send_item(ACTION_UPDATE, key_shared, -32'sd50);
      send_item(ACTION_ESTIMATE, key_shared, '0);
      send_item(ACTION_ESTIMATE, key_base, '0);
      send_item(ACTION_ESTIMATE, '0, 32'sh7FFF_FFFF);
      send_item(ACTION_UPDATE, key_base, '0);
      send_item(ACTION_ESTIMATE, key_base, 32'sh8000_0000);
   endtask

   // Random traffic: mostly a small key pool sharing top bits so rows collide
   task automatic run_random(input int count);
      logic [INDEX_BITS-1:0]     top_bits [4];
      logic [KEY_W-1:0]          key_pool [POOL_KEYS];
      logic [KEY_W-1:0]          key;
      logic                      action;
      logic signed [DELTA_W-1:0] delta;
      int                        pick;
      for (int i = 0; i < 4; i++) top_bits[i] = INDEX_BITS'($urandom);
      for (int i = 0; i < POOL_KEYS; i++) begin
         key_pool[i] = rand_word64();
         key_pool[i][KEY_W-1 -: INDEX_BITS] = top_bits[$urandom_range(0, 3)];
      end
      repeat (count) begin
         key = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                            : rand_word64();
         action = ($urandom_range(0, 99) < 45) ? ACTION_ESTIMATE : ACTION_UPDATE;
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            delta = $urandom_range(0, 400);
            delta = delta - 32'sd200;
         end else if (pick < 85) begin
            delta = $urandom;
         end else begin
            case ($urandom_range(0, 3))
               0:       delta = 32'sh7FFF_FFFF;
               1:       delta = 32'sh8000_0000;
               2:       delta = -32'sd1;
               default: delta = '0;
            endcase
         end
         send_item(action, key, delta);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // each phase reprograms the seeds while the unit is idle, then runs traffic
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin
               write_seed(REG_SEED_ROW0, '0);
               write_seed(REG_SEED_ROW1, '1);
               write_seed(REG_SEED_ROW2, 64'd2);
               write_seed(REG_SEED_ROW3, 64'h8000_0000_0000_0000);
               write_seed(REG_PAST_LAST, rand_word64());
               write_seed(REG_INDEX_TOP, rand_word64());
            end
            1: begin
               for (int i = 0; i < NUM_SEEDS; i++)
                  write_seed(REG_SEED_ROW0 + CSR_INDEX_W'(i),
                             SEED_W'($urandom_range(0, 15)));
            end
            3: begin
               for (int i = 0; i < NUM_SEEDS; i++)
                  write_seed(REG_SEED_ROW0 + CSR_INDEX_W'(i), '1);
            end
            4: begin
               // even values come back as the reset seeds
               for (int i = 0; i < NUM_SEEDS; i++)
                  write_seed(REG_SEED_ROW0 + CSR_INDEX_W'(i), SEED_W'(2 * i));
            end
            default: begin
               for (int i = 0; i < NUM_SEEDS; i++)
                  write_seed(REG_SEED_ROW0 + CSR_INDEX_W'(i), rand_word64());
               repeat (3) write_seed(CSR_INDEX_W'($urandom_range(0, 255)), rand_word64());
            end
         endcase
         csr_valid <= 1'b0;
         case (phase % 3)
            0:       gap_max = 0;
            1:       gap_max = 30;
            default: gap_max = 6;
         endcase
         run_random(ITEMS_PER_PHASE);
      end

      settle();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
